// ===== rtl/kil_pkg.sv =====
// ----------------------------------------------------------------------------
// kil_pkg: shared types and constants for the keyframe interval lookup
// Command codes, register indexes, Q16.16 / Q0.16 constants and the request
// and response words of the shared restoring divider.
// ----------------------------------------------------------------------------
package kil_pkg;

   localparam int TIME_WORD_BITS = 32;
   localparam int FCNT_BITS      = 9;
   localparam int FRAME_BITS     = 8;
   localparam int PROG_BITS      = 17;
   localparam int QUOT_BITS      = 16;
   localparam int STEP_BITS      = 6;

   // command codes carried by req_cmd
   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_PAIR   = 2'd1;
   localparam logic [1:0] CMD_SINGLE = 2'd2;
   localparam logic [1:0] CMD_NONE   = 2'd3;

   // register indexes on the csr port
   localparam logic CSR_ANIM_LENGTH = 1'b0;
   localparam logic CSR_FRAME_COUNT = 1'b1;

   localparam logic [PROG_BITS-1:0] ONE_Q16    = 17'h1_0000;
   localparam logic [STEP_BITS-1:0] MOD_STEPS  = 6'd32;
   localparam logic [STEP_BITS-1:0] FRAC_STEPS = 6'd16;

   typedef struct packed {
      logic                      start;
      logic [TIME_WORD_BITS-1:0] rem_init;
      logic [TIME_WORD_BITS-1:0] dividend;
      logic [TIME_WORD_BITS-1:0] divisor;
      logic [STEP_BITS-1:0]      steps;
   } kil_div_req_type;

   typedef struct packed {
      logic                      done;
      logic [TIME_WORD_BITS-1:0] rem;
      logic [QUOT_BITS-1:0]      quot;
   } kil_div_rsp_type;

endpackage

// ===== rtl/kil_ram.sv =====
// ----------------------------------------------------------------------------
// kil_ram: generic single-port synchronous RAM
// One write or one read per cycle; read data registered.
// ----------------------------------------------------------------------------
module kil_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/kil_div.sv =====
// ----------------------------------------------------------------------------
// kil_div: shared restoring divider, one quotient bit per cycle
// Serves both the time wrap (remainder of a 32-bit time) and the Q0.16
// interpolation fraction (quotient of diff * 65536 by the span).
// ----------------------------------------------------------------------------
module kil_div (
   input  logic                     clock,
   input  logic                     reset,
   input  kil_pkg::kil_div_req_type div_req,
   output kil_pkg::kil_div_rsp_type div_rsp
);

   logic                                   busy_ff, busy_in;
   logic                                   done_ff, done_in;
   logic [kil_pkg::STEP_BITS-1:0]          cnt_ff, cnt_in;
   logic [kil_pkg::TIME_WORD_BITS-1:0]     rem_ff, rem_in;
   logic [kil_pkg::TIME_WORD_BITS-1:0]     dvd_ff, dvd_in;
   logic [kil_pkg::TIME_WORD_BITS-1:0]     dvs_ff, dvs_in;
   logic [kil_pkg::QUOT_BITS-1:0]          quot_ff, quot_in;
   logic [kil_pkg::TIME_WORD_BITS:0]       rem_shift;
   logic [kil_pkg::TIME_WORD_BITS:0]       rem_sub;
   logic                                   fits;

   always_comb begin
      rem_shift = {rem_ff, dvd_ff[kil_pkg::TIME_WORD_BITS-1]};
      rem_sub   = rem_shift - {1'b0, dvs_ff};
      fits      = rem_shift >= {1'b0, dvs_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      quot_in = quot_ff;

      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = div_req.steps;
         rem_in  = div_req.rem_init;
         dvd_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
         quot_in = '0;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits the word
         rem_in  = fits ? rem_sub[kil_pkg::TIME_WORD_BITS-1:0]
                        : rem_shift[kil_pkg::TIME_WORD_BITS-1:0];
         dvd_in  = {dvd_ff[kil_pkg::TIME_WORD_BITS-2:0], 1'b0};
         quot_in = {quot_ff[kil_pkg::QUOT_BITS-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == kil_pkg::STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
      quot_ff <= quot_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.rem  = rem_ff;
   assign div_rsp.quot = quot_ff;

endmodule

// ===== rtl/keyframe_interval_lookup.sv =====
// ----------------------------------------------------------------------------
// keyframe_interval_lookup: keyframe bracket search over a stamp table
// Loads Q16.16 stamps into a RAM and answers wrapped pair queries and clamped
// single queries with frame indices and a Q1.16 interpolation fraction.
// ----------------------------------------------------------------------------
// A load gives no result word. A query is taken only when the previous one has
// left the engine; each probe of the lower-bound search passes a read state and
// a compare state, ceil(log2(n+1)) probes for n frames in use (9 for 256). A
// pair query whose time exceeds a nonzero length first has the time wrapped by
// the divider. A pair that finds a bracket then fetches both bracketing stamps
// and, unless the fraction is zero or one, divides for it before the hand-off;
// a clamped query past the length goes straight to the hand-off. The single RAM
// port (one stamp read per probe) and the shared one-bit-per-cycle divider set
// the query time. The next query can be taken while the last result word still
// waits in the output register. Table entries are undefined until loaded.
// ----------------------------------------------------------------------------
module keyframe_interval_lookup #(
   parameter int MAX_FRAMES = 256,
   parameter int TIME_BITS  = 32
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_entry_index,
   input  logic [31:0] req_time_value,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_first_frame,
   output logic [7:0]  rsp_second_frame,
   output logic        rsp_is_pair,
   output logic [16:0] rsp_progress,

   input  logic        csr_wen,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int AW         = $clog2(MAX_FRAMES);
   localparam int STAMP_BITS = (TIME_BITS < kil_pkg::TIME_WORD_BITS) ?
                               TIME_BITS : kil_pkg::TIME_WORD_BITS;
   localparam logic [31:0] TIME_MASK = (TIME_BITS >= kil_pkg::TIME_WORD_BITS) ?
                               32'hFFFF_FFFF : 32'((64'd1 << TIME_BITS) - 64'd1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRAP,
      ST_SEARCH_RD,
      ST_SEARCH_CMP,
      ST_READ_HI,
      ST_CALC,
      ST_FRAC,
      ST_RESULT
   } state_type;

   state_type                        state_ff, state_in;
   logic [31:0]                      len_ff, len_in;
   logic [kil_pkg::FCNT_BITS-1:0]    fcnt_ff, fcnt_in;
   logic [1:0]                       cmd_ff, cmd_in;
   logic [31:0]                      t_ff, t_in;
   logic [31:0]                      lo_ff, lo_in;
   logic [kil_pkg::FCNT_BITS-1:0]    srch_first_ff, srch_first_in;
   logic [kil_pkg::FCNT_BITS-1:0]    srch_count_ff, srch_count_in;
   logic [7:0]                       res_first_ff, res_first_in;
   logic                             res_pair_ff, res_pair_in;
   logic [16:0]                      res_prog_ff, res_prog_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [7:0]                       rsp_first_ff, rsp_first_in;
   logic [7:0]                       rsp_second_ff, rsp_second_in;
   logic                             rsp_pair_ff, rsp_pair_in;
   logic [16:0]                      rsp_prog_ff, rsp_prog_in;

   logic [kil_pkg::FCNT_BITS-1:0]    nfr;
   logic [kil_pkg::FCNT_BITS-1:0]    half;
   logic [kil_pkg::FCNT_BITS-1:0]    probe;
   logic [31:0]                      t_query;
   logic [31:0]                      stamp;
   logic [31:0]                      diff;
   logic [31:0]                      span;

   logic                             ram_we;
   logic [AW-1:0]                    ram_addr;
   logic [STAMP_BITS-1:0]            ram_wdata;
   logic [STAMP_BITS-1:0]            ram_rdata;

   kil_pkg::kil_div_req_type         div_req;
   kil_pkg::kil_div_rsp_type         div_rsp;

   kil_ram #(
      .WIDTH (STAMP_BITS),
      .DEPTH (MAX_FRAMES)
   ) u_stamp_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   kil_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // frame count in use: zero acts as one, clamp to the table depth
   always_comb begin
      if (fcnt_ff == '0) begin
         nfr = kil_pkg::FCNT_BITS'(1);
      end else if (32'(fcnt_ff) > 32'(MAX_FRAMES)) begin
         nfr = kil_pkg::FCNT_BITS'(MAX_FRAMES);
      end else begin
         nfr = fcnt_ff;
      end
   end

   assign t_query = req_time_value & TIME_MASK;
   assign stamp   = 32'(ram_rdata);
   assign half    = srch_count_ff >> 1;
   assign probe   = srch_first_ff + half;
   assign diff    = t_ff - lo_ff;
   assign span    = stamp - lo_ff;

   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      fcnt_in       = fcnt_ff;
      cmd_in        = cmd_ff;
      t_in          = t_ff;
      lo_in         = lo_ff;
      srch_first_in = srch_first_ff;
      srch_count_in = srch_count_ff;
      res_first_in  = res_first_ff;
      res_pair_in   = res_pair_ff;
      res_prog_in   = res_prog_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      rsp_pair_in   = rsp_pair_ff;
      rsp_prog_in   = rsp_prog_ff;
      ram_we        = 1'b0;
      ram_addr      = '0;
      ram_wdata     = STAMP_BITS'(req_time_value);
      div_req       = '0;

      if (csr_wen) begin
         unique case (csr_index)
            kil_pkg::CSR_ANIM_LENGTH: len_in  = csr_wdata;
            kil_pkg::CSR_FRAME_COUNT: fcnt_in = csr_wdata[kil_pkg::FCNT_BITS-1:0];
         endcase
      end

      // drop the word once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in        = req_cmd;
               t_in          = t_query;
               res_first_in  = '0;
               res_pair_in   = 1'b0;
               res_prog_in   = '0;
               srch_first_in = '0;
               srch_count_in = nfr;
               unique case (req_cmd)
                  kil_pkg::CMD_LOAD: begin
                     if (32'(req_entry_index) < 32'(MAX_FRAMES)) begin
                        ram_we   = 1'b1;
                        ram_addr = AW'(req_entry_index);
                     end
                  end
                  kil_pkg::CMD_PAIR: begin
                     if (len_ff != '0 && t_query > len_ff) begin
                        div_req.start    = 1'b1;
                        div_req.rem_init = '0;
                        div_req.dividend = t_query;
                        div_req.divisor  = len_ff;
                        div_req.steps    = kil_pkg::MOD_STEPS;
                        state_in         = ST_WRAP;
                     end else begin
                        state_in = ST_SEARCH_RD;
                     end
                  end
                  kil_pkg::CMD_SINGLE: begin
                     if (t_query > len_ff) begin
                        res_first_in = 8'(nfr - 1'b1);
                        state_in     = ST_RESULT;
                     end else begin
                        state_in = ST_SEARCH_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_WRAP: begin
            if (div_rsp.done) begin
               // wrapped time lies in (0, length]
               t_in     = (div_rsp.rem == '0) ? len_ff : div_rsp.rem;
               state_in = ST_SEARCH_RD;
            end
         end

         ST_SEARCH_RD: begin
            if (srch_count_ff == '0) begin
               if (srch_first_ff != '0 && srch_first_ff < nfr) begin
                  if (cmd_ff == kil_pkg::CMD_PAIR) begin
                     ram_addr = AW'(srch_first_ff - 1'b1);
                     state_in = ST_READ_HI;
                  end else begin
                     res_first_in = 8'(srch_first_ff - 1'b1);
                     state_in     = ST_RESULT;
                  end
               end else begin
                  state_in = ST_RESULT;
               end
            end else begin
               ram_addr = AW'(probe);
               state_in = ST_SEARCH_CMP;
            end
         end

         ST_SEARCH_CMP: begin
            if (stamp < t_ff) begin
               srch_first_in = probe + 1'b1;
               srch_count_in = srch_count_ff - half - 1'b1;
            end else begin
               srch_count_in = half;
            end
            state_in = ST_SEARCH_RD;
         end

         ST_READ_HI: begin
            lo_in    = stamp;
            ram_addr = AW'(srch_first_ff);
            state_in = ST_CALC;
         end

         ST_CALC: begin
            res_first_in = 8'(srch_first_ff - 1'b1);
            res_pair_in  = 1'b1;
            if (stamp <= lo_ff || t_ff <= lo_ff) begin
               res_prog_in = '0;
               state_in    = ST_RESULT;
            end else if (diff >= span) begin
               res_prog_in = kil_pkg::ONE_Q16;
               state_in    = ST_RESULT;
            end else begin
               div_req.start    = 1'b1;
               div_req.rem_init = diff;
               div_req.dividend = '0;
               div_req.divisor  = span;
               div_req.steps    = kil_pkg::FRAC_STEPS;
               state_in         = ST_FRAC;
            end
         end

         ST_FRAC: begin
            if (div_rsp.done) begin
               res_prog_in = {1'b0, div_rsp.quot};
               state_in    = ST_RESULT;
            end
         end

         ST_RESULT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_first_in  = res_first_ff;
               rsp_second_in = res_pair_ff ? 8'(srch_first_ff) : res_first_ff;
               rsp_pair_in   = res_pair_ff;
               rsp_prog_in   = res_prog_ff;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      t_ff          <= t_in;
      lo_ff         <= lo_in;
      srch_first_ff <= srch_first_in;
      srch_count_ff <= srch_count_in;
      res_first_ff  <= res_first_in;
      res_pair_ff   <= res_pair_in;
      res_prog_ff   <= res_prog_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      rsp_pair_ff   <= rsp_pair_in;
      rsp_prog_ff   <= rsp_prog_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         len_ff       <= '0;
         fcnt_ff      <= kil_pkg::FCNT_BITS'(1);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         len_ff       <= len_in;
         fcnt_ff      <= fcnt_in;
      end
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_first_frame  = rsp_first_ff;
   assign rsp_second_frame = rsp_second_ff;
   assign rsp_is_pair      = rsp_pair_ff;
   assign rsp_progress     = rsp_prog_ff;

endmodule

// ===== rtl/kil_checker.sv =====
// ----------------------------------------------------------------------------
// kil_checker: port-level checks for the keyframe interval lookup
// Watches the request and result channels and flags inconsistent words.
// ----------------------------------------------------------------------------
module kil_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_cmd,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_first_frame,
   input logic [7:0]  rsp_second_frame,
   input logic        rsp_is_pair,
   input logic [16:0] rsp_progress
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_first_frame) &&
         $stable(rsp_second_frame) && $stable(rsp_is_pair) && $stable(rsp_progress))
      else $error("result word changed while stalled");

   // a single result names one frame and carries no fraction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_pair |->
         rsp_first_frame == rsp_second_frame && rsp_progress == 17'd0)
      else $error("single result with two frames or a fraction");

   // a pair brackets adjacent frames
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_pair |-> rsp_second_frame == rsp_first_frame + 8'd1)
      else $error("pair frames not adjacent");

   // fraction never exceeds one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_progress <= 17'h1_0000)
      else $error("fraction above one");

   // a load produces no result word
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_cmd == kil_pkg::CMD_LOAD |=> !$rose(rsp_valid))
      else $error("result word after a load");

endmodule

bind keyframe_interval_lookup kil_checker u_kil_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_cmd          (req_cmd),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_first_frame  (rsp_first_frame),
   .rsp_second_frame (rsp_second_frame),
   .rsp_is_pair      (rsp_is_pair),
   .rsp_progress     (rsp_progress)
);

// ===== tb/keyframe_interval_lookup_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_interval_lookup_test: self-checking bench for the keyframe lookup
// Loads stamp tables, then drives wrapped pair queries and clamped single
// queries under several length and frame-count settings and idling patterns.
// Every result word is checked field by field against an in-bench bracket
// predictor, or against the expected word given in a directed row.
// ----------------------------------------------------------------------------
module keyframe_interval_lookup_test;
   import kil_pkg::*;

   localparam int TABLE_DEPTH   = 256;
   localparam int SETTLE_CYCLES = 120;
   localparam int PHASES        = 8;
   localparam int PHASE_WORDS   = 24;

   typedef struct packed {
      logic [FRAME_BITS-1:0] first_frame;
      logic [FRAME_BITS-1:0] second_frame;
      logic                  is_pair;
      logic [PROG_BITS-1:0]  progress;
   } bracket_type;

   localparam bracket_type NO_FRAME = '0;

   typedef enum logic {ROW_WORD, ROW_REG} row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      logic                      reg_sel;
      logic [1:0]                cmd;
      logic [7:0]                slot;
      logic [TIME_WORD_BITS-1:0] value;
      logic                      given;
      bracket_type               want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_cmd = CMD_NONE;
   logic [7:0]  req_entry_index = '0;
   logic [31:0] req_time_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_first_frame;
   logic [7:0]  rsp_second_frame;
   logic        rsp_is_pair;
   logic [16:0] rsp_progress;
   logic        csr_wen = 1'b0;
   logic        csr_index = CSR_ANIM_LENGTH;
   logic [31:0] csr_wdata = '0;

   // predictor state
   logic [TIME_WORD_BITS-1:0] stamp_mem [TABLE_DEPTH];
   logic [TIME_WORD_BITS-1:0] anim_len_q = '0;
   logic [FCNT_BITS-1:0]      frame_count_q = 9'd1;
   bracket_type               pending_brackets [$];

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned fault_count    = 0;

   stim_row_type directed_rows [25] = '{
      '{ROW_WORD, CSR_ANIM_LENGTH, CMD_LOAD,   8'd0,   32'h0001_0000, 1'b0, NO_FRAME},
      '{ROW_WORD, CSR_ANIM_LENGTH, CMD_PAIR,   8'd0,   32'h0002_0000, 1'b1, NO_FRAME},
      '{ROW_WORD, CSR_ANIM_LENGTH, CMD_SINGLE, 8'd0,   32'h0000_0000, 1'b1, NO_FRAME},
      '{ROW_WORD, CSR_ANIM_LENGTH, CMD_SINGLE, 8'd0,   32'hFFFF_FFFF, 1'b1, NO_FRAME},
      '{ROW_WORD, CSR_ANIM_LENGTH, CMD_NONE,   8'd7,   32'h1234_5678, 1'b0, NO_FRAME},
      '{ROW_REG,  CSR_ANIM_LENGTH, CMD_NONE,   8'd0,   32'h0004_0000, 1'b0, NO_FRAME},
      '{ROW_REG,  CSR_FRAME_COUNT, CMD_NONE,   8'd0,   32'd4,         1'b0, NO_FRAME},
      '{ROW_WORD, CSR_ANIM_LENGTH, CMD_LOAD,   8'd0,   32'h0001_0000, 1'b0, NO_FRAME},
      '{ROW_WORD, CSR_ANIM_LENGTH, CMD_LOAD,   8'd1,   32'h0002_0000, 1'b0, NO_FRAME},
      '{ROW_WORD, CSR_ANIM_LENGTH, CMD_LOAD,   8'd2,   32'h0002_0000, 1'b0, NO_FRAME},
      '{ROW_WORD, CSR_ANIM_LENGTH, CMD_LOAD,   8'd3,   32'h0003_8000, 1'b0, NO_FRAME},
      // before and at the first stamp: no pair
      '{ROW_WORD, CSR_ANIM_LENGTH, CMD_PAIR,   8'd0,   32'h0000_0001, 1'b1, NO_FRAME},
      '{ROW_WORD, CSR_ANIM_LENGTH, CMD_PAIR,   8'd0,   32'h0001_0000, 1'b1, NO_FRAME},
      '{ROW_WORD, CSR_ANIM_LENGTH, CMD_PAIR,   8'd0,   32'h0001_8000, 1'b1,
        '{8'd0, 8'd1, 1'b1, 17'h0_8000}},
      '{ROW_WORD, CSR_ANIM_LENGTH, CMD_PAIR,   8'd0,   32'h0003_0000, 1'b0, NO_FRAME},
      // at the length itself, no wrap, past all stamps
      '{ROW_WORD, CSR_ANIM_LENGTH, CMD_PAIR,   8'd0,   32'h0004_0000, 1'b1, NO_FRAME},
      // zero remainder wraps to the length
      '{ROW_WORD, CSR_ANIM_LENGTH, CMD_PAIR,   8'd0,   32'h0008_0000, 1'b1, NO_FRAME},
      '{ROW_WORD, CSR_ANIM_LENGTH, CMD_PAIR,   8'd0,   32'h0005_8000, 1'b0, NO_FRAME},
      '{ROW_WORD, CSR_ANIM_LENGTH, CMD_PAIR,   8'd0,   32'hFFFF_FFFF, 1'b0, NO_FRAME},
      '{ROW_WORD, CSR_ANIM_LENGTH, CMD_SINGLE, 8'd0,   32'h0005_0000, 1'b1,
        '{8'd3, 8'd3, 1'b0, 17'h0_0000}},
      '{ROW_WORD, CSR_ANIM_LENGTH, CMD_SINGLE, 8'd0,   32'h0004_0000, 1'b1, NO_FRAME},
      '{ROW_WORD, CSR_ANIM_LENGTH, CMD_SINGLE, 8'd0,   32'h0001_8000, 1'b0, NO_FRAME},
      '{ROW_WORD, CSR_ANIM_LENGTH, CMD_SINGLE, 8'hAA,  32'h0003_0000, 1'b0, NO_FRAME},
      '{ROW_WORD, CSR_ANIM_LENGTH, CMD_NONE,   8'hFF,  32'hFFFF_FFFF, 1'b0, NO_FRAME},
      '{ROW_WORD, CSR_ANIM_LENGTH, CMD_LOAD,   8'hFF,  32'hFFFF_FFFF, 1'b0, NO_FRAME}
   };

   keyframe_interval_lookup #(
      .MAX_FRAMES (TABLE_DEPTH),
      .TIME_BITS  (32)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_entry_index  (req_entry_index),
      .req_time_value   (req_time_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_first_frame  (rsp_first_frame),
      .rsp_second_frame (rsp_second_frame),
      .rsp_is_pair      (rsp_is_pair),
      .rsp_progress     (rsp_progress),
      .csr_wen          (csr_wen),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("keyframe_interval_lookup regression: fail");
      $finish;
   end

   task automatic report(input string line);
      $display("%t  %s", $realtime, line);
      fault_count++;
   endtask

   // Queue one owed result word at the tail.
   function automatic void owe_bracket(input bracket_type b);
      pending_brackets.insert(pending_brackets.size(), b);
   endfunction

   function automatic int unsigned frames_in_use();
      if (frame_count_q == 0) return 1;
      if (frame_count_q > TABLE_DEPTH) return TABLE_DEPTH;
      return frame_count_q;
   endfunction

   function automatic int unsigned lower_bound_of(input logic [31:0] t, input int unsigned n);
      int unsigned first, count, half, probe;
      first = 0;
      count = n;
      while (count > 0) begin
         half  = count / 2;
         probe = first + half;
         if (probe < TABLE_DEPTH && stamp_mem[probe] < t) begin
            first = probe + 1;
            count = count - (half + 1);
         end else begin
            count = half;
         end
      end
      return first;
   endfunction

   // Work out the result word of a query; returns 0 where none is due.
   function automatic bit bracket_of(input logic [1:0] cmd, input logic [31:0] t_in,
                                     output bracket_type b);
      int unsigned n, idx;
      logic [31:0] t, lo, hi;
      logic [63:0] span, diff, r;
      b = NO_FRAME;
      t = t_in;
      n = frames_in_use();
      if (cmd == CMD_PAIR) begin
         if (anim_len_q != 0 && t > anim_len_q) begin
            r = 64'(t) % 64'(anim_len_q);
            t = (r == 0) ? anim_len_q : r[31:0];
         end
         idx = lower_bound_of(t, n);
         if (idx != 0 && idx < n) begin
            b.first_frame  = 8'(idx - 1);
            b.second_frame = 8'(idx);
            b.is_pair      = 1'b1;
            lo = stamp_mem[idx - 1];
            hi = stamp_mem[idx];
            if (hi > lo && t > lo) begin
               span = 64'(hi) - 64'(lo);
               diff = 64'(t) - 64'(lo);
               b.progress = (diff >= span) ? ONE_Q16 : 17'((diff << 16) / span);
            end
         end
         return 1'b1;
      end
      if (cmd == CMD_SINGLE) begin
         if (t > anim_len_q) begin
            b.first_frame = 8'(n - 1);
         end else begin
            idx = lower_bound_of(t, n);
            if (idx != 0 && idx < n) b.first_frame = 8'(idx - 1);
         end
         b.second_frame = b.first_frame;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Offer one word, hold it through stalls, then fold it into the predictor.
   task automatic push_word(input logic [1:0] cmd, input logic [7:0] slot,
                            input logic [31:0] stamp, input logic given,
                            input bracket_type want);
      bracket_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_entry_index <= slot;
      req_time_value  <= stamp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (cmd == CMD_LOAD) begin
         stamp_mem[slot] = stamp;
      end else if (bracket_of(cmd, stamp, predicted)) begin
         owe_bracket(given ? want : predicted);
      end
   endtask

   // Drain: nothing owed, then allow for loads or a dropped word still in flight.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_brackets.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic sel, input logic [31:0] data);
      csr_wen   <= 1'b1;
      csr_index <= sel;
      csr_wdata <= data;
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
      if (sel == CSR_ANIM_LENGTH) anim_len_q = data;
      else frame_count_q = data[FCNT_BITS-1:0];
   endtask

   always @(posedge clock) begin : rsp_side
      bracket_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_brackets.size() == 0) begin
               report("result word with nothing expected");
            end else begin
               want = pending_brackets.pop_front();
               if (rsp_first_frame !== want.first_frame)
                  report($sformatf("first_frame got %0d want %0d",
                                   rsp_first_frame, want.first_frame));
               if (rsp_second_frame !== want.second_frame)
                  report($sformatf("second_frame got %0d want %0d",
                                   rsp_second_frame, want.second_frame));
               if (rsp_is_pair !== want.is_pair)
                  report($sformatf("is_pair got %0d want %0d", rsp_is_pair, want.is_pair));
               if (rsp_progress !== want.progress)
                  report($sformatf("progress got %0d want %0d",
                                   rsp_progress, want.progress));
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   initial begin
      int unsigned      i, ph, n, k, words, roll;
      longint unsigned  cur, gap, span_max;
      logic [31:0]      len, t, lo, hi, step;
      logic [FCNT_BITS-1:0] fcount;
      bit               full_table;

      full_table = 1'b0;
      foreach (stamp_mem[j]) stamp_mem[j] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < $size(directed_rows); i++) begin
         if (directed_rows[i].kind == ROW_REG) begin
            settle();
            write_reg(directed_rows[i].reg_sel, directed_rows[i].value);
         end else begin
            push_word(directed_rows[i].cmd, directed_rows[i].slot, directed_rows[i].value,
                      directed_rows[i].given, directed_rows[i].want);
         end
      end

      for (ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin
               len    = '0;
               fcount = 9'd1;
            end
            1: begin
               len    = 32'hFFFF_FFFF;
               fcount = 9'd256;
            end
            2: begin
               len    = $urandom_range(1, 32'h0010_0000);
               fcount = 9'd0;
            end
            3: begin
               len    = $urandom;
               fcount = 9'($urandom_range(257, 511));
            end
            default: begin
               len    = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom;
               fcount = 9'($urandom_range(2, 16));
            end
         endcase
         settle();
         write_reg(CSR_ANIM_LENGTH, len);
         write_reg(CSR_FRAME_COUNT, {23'($urandom), fcount});
         case (ph % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 52;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 52;
            end
            default: begin
               send_idle_pct  = 38;
               recv_stall_pct = 38;
            end
         endcase

         // fill every slot in use with non-descending stamps, which may run past the length;
         // keep a full table that is already loaded
         n        = frames_in_use();
         span_max = (len != 0) ? len : 32'hFFFF_FFFF;
         gap      = span_max / (n + 1);
         if (gap == 0) gap = 1;
         if (n < TABLE_DEPTH || !full_table) begin
            cur = $urandom_range(0, 32'(gap));
            for (i = 0; i < n; i++) begin
               push_word(CMD_LOAD, 8'(i), 32'(cur), 1'b0, NO_FRAME);
               step = ($urandom_range(0, 19) == 0) ? 32'h0 : $urandom_range(0, 32'(2 * gap));
               cur  = cur + step;
               if (cur > 64'hFFFF_FFFF) cur = 64'hFFFF_FFFF;
            end
            if (n == TABLE_DEPTH) full_table = 1'b1;
         end

         words = 0;
         while (words < PHASE_WORDS) begin
            roll = $urandom_range(0, 99);
            k    = $urandom_range(0, n - 1);
            if (roll < 75) begin
               case ($urandom_range(0, 9))
                  0: t = stamp_mem[k];
                  1, 2: t = stamp_mem[k] + $urandom_range(0, 32'(gap));
                  3: t = stamp_mem[k] - 1;
                  4: t = $urandom;
                  5: t = len + $urandom_range(0, 2) - 1;
                  6: t = len * $urandom_range(1, 3) + stamp_mem[k] + $urandom_range(0, 3);
                  7: t = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
                  default: begin
                     if (k + 1 < n && stamp_mem[k + 1] > stamp_mem[k])
                        t = stamp_mem[k] + $urandom_range(1, stamp_mem[k + 1] - stamp_mem[k]);
                     else
                        t = stamp_mem[k] + 1;
                  end
               endcase
               push_word((roll < 40) ? CMD_PAIR : CMD_SINGLE, 8'($urandom), t, 1'b0,
                         NO_FRAME);
               words++;
            end else if (roll < 92) begin
               // mostly keep the table ascending; now and then scribble anywhere
               if ($urandom_range(0, 9) < 7) begin
                  lo = (k == 0) ? 32'h0 : stamp_mem[k - 1];
                  hi = (k == n - 1) ? stamp_mem[k] : stamp_mem[k + 1];
                  t  = (hi >= lo) ? lo + $urandom_range(0, hi - lo) : $urandom;
                  push_word(CMD_LOAD, 8'(k), t, 1'b0, NO_FRAME);
               end else begin
                  push_word(CMD_LOAD, 8'($urandom), $urandom, 1'b0, NO_FRAME);
               end
               words++;
            end else begin
               push_word(CMD_NONE, 8'($urandom), $urandom, 1'b0, NO_FRAME);
            end
         end
      end

      settle();
      if (fault_count == 0) begin
         $display("keyframe_interval_lookup regression: pass");
      end else begin
         $display("keyframe_interval_lookup regression: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/kil_pkg.sv
rtl/kil_ram.sv
rtl/kil_div.sv
rtl/keyframe_interval_lookup.sv
rtl/kil_checker.sv
tb/keyframe_interval_lookup_test.sv
